### rtl/i2c_mbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by the top level and its port checker; no dependencies.
`default_nettype none

package i2c_mbs_pkg;

  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned InDataWidth = 24;
  localparam int unsigned OutDataWidth = 16;

  // MSB of a byte, sent and sampled first
  localparam logic [ByteWidth-1:0] MsbMask = 8'h80;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_INIT      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5,
    OP_POLL      = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_INIT  = 10'b00_0000_0010,
    ST_START = 10'b00_0000_0100,
    ST_BOUT  = 10'b00_0000_1000,
    ST_WACK  = 10'b00_0001_0000,
    ST_REL   = 10'b00_0010_0000,
    ST_RBIT  = 10'b00_0100_0000,
    ST_RACK  = 10'b00_1000_0000,
    ST_PACK  = 10'b01_0000_0000,
    ST_STOP  = 10'b10_0000_0000
  } state_e;

  // One pin phase as it leaves the block
  typedef struct packed {
    logic [3:0]           pad;
    logic                 no_ack;
    logic [ByteWidth-1:0] read_byte;
    logic                 sda_released;
    logic                 sda;
    logic                 scl;
  } phase_t;

endpackage

`default_nettype wire

### rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: expands one command into a run of SCL/SDA pin phases.
// Depends on i2c_mbs_pkg.
`default_nettype none

// One command enters on the slave stream and leaves as one transfer per pin
// phase on the master stream, the final phase marked by tlast and carrying the
// read byte (reads) and the no-acknowledge flag (poll). A command holds the
// block until its last phase is produced, sink stalls included; phases: init 1,
// start 4, stop 3, write 27, read 20, poll 34. s_axis_tready returns the
// cycle after the last phase is produced. A single 8-bit shift register, stepped
// by a phase and bit counter under the command sequencer, serialises the byte
// to write. Opcode 7 is taken and dropped with no output. Pin levels reset to
// the idle bus (SCL and SDA high, SDA driven).
module i2c_master_bit_sequencer (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     s_axis_tvalid,
  output logic                                    s_axis_tready,
  // data_byte [7:0], line_bits [15:8], ack_line [16], zero [23:17]
  input  wire  [i2c_mbs_pkg::InDataWidth-1:0]     s_axis_tdata,
  // opcode [2:0]
  input  wire  [i2c_mbs_pkg::OpcodeWidth-1:0]     s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire                                     m_axis_tready,
  // scl [0], sda [1], sda_released [2], read_byte [10:3], no_ack [11], zero [15:12]
  output logic [i2c_mbs_pkg::OutDataWidth-1:0]    m_axis_tdata,
  output logic                                    m_axis_tlast
);
  import i2c_mbs_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [1:0]           ph_q, ph_d;
  logic [2:0]           bit_q, bit_d;
  logic [ByteWidth-1:0] shreg_q, shreg_d;
  logic [ByteWidth-1:0] lines_q, lines_d;
  logic                 ack_q, ack_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 mode_q, mode_d;
  logic                 out_valid_q, out_valid_d;
  phase_t               out_q, out_d;
  logic                 out_last_q, out_last_d;

  logic s_fire;
  logic step_en;
  logic rel_ph;
  logic done;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign step_en       = (state_q != ST_IDLE) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ph_d    = ph_q;
    bit_d   = bit_q;
    shreg_d = shreg_q;
    lines_d = lines_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    mode_d  = mode_q;
    rel_ph  = mode_q;
    done    = 1'b0;

    if (s_fire) begin
      op_d    = op_e'(s_axis_tuser);
      shreg_d = s_axis_tdata[ByteWidth-1:0];
      lines_d = s_axis_tdata[2*ByteWidth-1:ByteWidth];
      ack_d   = s_axis_tdata[2*ByteWidth];
      ph_d    = '0;
      bit_d   = '0;
      unique case (op_e'(s_axis_tuser))
        OP_INIT:                  state_d = ST_INIT;
        OP_START, OP_POLL:        state_d = ST_START;
        OP_STOP:                  state_d = ST_STOP;
        OP_WRITE:                 state_d = ST_BOUT;
        OP_READ_ACK, OP_READ_NACK: state_d = ST_REL;
        default:                  state_d = ST_IDLE;
      endcase
    end else if (step_en) begin
      unique case (state_q)
        ST_INIT: begin
          mode_d  = 1'b0;
          rel_ph  = 1'b0;
          done    = 1'b1;
        end
        ST_START: begin
          unique case (ph_q)
            2'd0:    scl_d = 1'b1;
            2'd1:    sda_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            ph_d = '0;
            if (op_q == OP_POLL) begin
              state_d = ST_BOUT;
            end else begin
              done = 1'b1;
            end
          end
        end
        ST_BOUT: begin
          // data, clock high, clock low; shift after the low edge
          unique case (ph_q)
            2'd0:    sda_d = (shreg_q & MsbMask) != '0;
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            ph_d    = '0;
            shreg_d = {shreg_q[ByteWidth-2:0], 1'b0};
            bit_d   = bit_q + 3'd1;
            if (bit_q == 3'd7) begin
              state_d = (op_q == OP_POLL) ? ST_REL : ST_WACK;
            end
          end
        end
        ST_WACK: begin
          unique case (ph_q)
            2'd0:    sda_d = 1'b0;
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            ph_d = '0;
            done = 1'b1;
          end
        end
        ST_REL: begin
          mode_d  = 1'b1;
          rel_ph  = 1'b1;
          sda_d   = 1'b1;
          state_d = (op_q == OP_POLL) ? ST_PACK : ST_RBIT;
        end
        ST_RBIT: begin
          scl_d = (ph_q == 2'd0);
          ph_d  = (ph_q == 2'd0) ? 2'd1 : 2'd0;
          if (ph_q != 2'd0) begin
            bit_d = bit_q + 3'd1;
            if (bit_q == 3'd7) begin
              state_d = ST_RACK;
            end
          end
        end
        ST_RACK: begin
          unique case (ph_q)
            2'd0: begin
              mode_d = 1'b0;
              rel_ph = 1'b0;
              sda_d  = (op_q == OP_READ_NACK);
            end
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            ph_d = '0;
            done = 1'b1;
          end
        end
        ST_PACK: begin
          // acknowledge clock; SDA goes back to driven after the low phase
          scl_d = (ph_q == 2'd0);
          ph_d  = (ph_q == 2'd0) ? 2'd1 : 2'd0;
          if (ph_q != 2'd0) begin
            mode_d  = 1'b0;
            state_d = ST_STOP;
          end
        end
        ST_STOP: begin
          unique case (ph_q)
            2'd0:    sda_d = 1'b0;
            2'd1:    scl_d = 1'b1;
            default: sda_d = 1'b1;
          endcase
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            ph_d = '0;
            done = 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
      if (done) begin
        state_d = ST_IDLE;
      end
    end
  end

  // output register: load a phase on each step, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    if (step_en) begin
      out_valid_d        = 1'b1;
      out_d.pad          = '0;
      out_d.scl          = scl_d;
      out_d.sda          = sda_d;
      out_d.sda_released = rel_ph;
      out_d.read_byte    = (done && (op_q == OP_READ_ACK || op_q == OP_READ_NACK))
                           ? lines_q : '0;
      out_d.no_ack       = done && (op_q == OP_POLL) && ack_q;
      out_last_d         = done;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      mode_q      <= 1'b0;
      ph_q        <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      mode_q      <= mode_d;
      ph_q        <= ph_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    shreg_q    <= shreg_d;
    lines_q    <= lines_d;
    ack_q      <= ack_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

### rtl/i2c_mbs_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_mbs_pkg.
`default_nettype none

module i2c_mbs_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire [i2c_mbs_pkg::InDataWidth-1:0]   s_axis_tdata,
  input wire [i2c_mbs_pkg::OpcodeWidth-1:0]   s_axis_tuser,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [i2c_mbs_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input wire                                  m_axis_tlast
);
  import i2c_mbs_pkg::*;

  phase_t ph;
  assign ph = m_axis_tdata;

  // a real command keeps the input closed while its phases run
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_NONE) |=> !s_axis_tready)
    else $error("input ready straight after a command transfer");

  // read byte and no-ack appear only on the final phase
  a_fields_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (ph.read_byte == '0 && !ph.no_ack))
    else $error("status fields set off the final phase");

  // a released SDA reads back high
  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ph.sda_released) |-> ph.sda)
    else $error("SDA low while released");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output transfer changed");

endmodule

bind i2c_master_bit_sequencer i2c_mbs_checker u_i2c_mbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### test/tb.sv
// Self-checking bench for the I2C master bit sequencer: drives commands on the
// slave stream and checks every pin phase on the master stream against a local
// expansion of each command. Depends on i2c_mbs_pkg and i2c_master_bit_sequencer.
`default_nettype none

module tb;
  import i2c_mbs_pkg::*;

  typedef logic [ByteWidth-1:0] byte_t;

  typedef struct {
    op_e   op;
    byte_t data;
    byte_t lines;
    logic  ack;
  } command_t;

  typedef struct packed {
    phase_t ph;
    logic   last;
  } pin_phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataWidth-1:0] s_axis_tdata = '0;
  logic [OpcodeWidth-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic m_axis_tlast;

  i2c_master_bit_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  command_t   cmd_pending[$];
  pin_phase_t pin_phases_due[$];
  int         live_cmds;
  int         mismatches;
  logic       cmd_taken;

  // Bus levels as the sequencer should hold them
  logic bus_scl;
  logic bus_sda;
  logic bus_sda_rel;

  // ---------------------------------------------------------------------------
  // Command expansion

  task automatic put_phase();
    pin_phase_t p;
    p = '0;
    p.ph.scl          = bus_scl;
    p.ph.sda          = bus_sda;
    p.ph.sda_released = bus_sda_rel;
    pin_phases_due.push_back(p);
  endtask

  task automatic drive_scl(input logic v);
    bus_scl = v;
    put_phase();
  endtask

  task automatic drive_sda(input logic v);
    bus_sda = v;
    put_phase();
  endtask

  task automatic start_cond();
    drive_scl(1'b1);
    drive_sda(1'b1);
    drive_sda(1'b0);
    drive_scl(1'b0);
  endtask

  task automatic stop_cond();
    drive_sda(1'b0);
    drive_scl(1'b1);
    drive_sda(1'b1);
  endtask

  task automatic shift_byte_out(input byte_t b);
    for (int i = ByteWidth - 1; i >= 0; i--) begin
      drive_sda(b[i]);
      drive_scl(1'b1);
      drive_scl(1'b0);
    end
  endtask

  task automatic release_sda();
    bus_sda_rel = 1'b1;
    bus_sda     = 1'b1;
    put_phase();
  endtask

  task automatic expand_command(input op_e op, input byte_t data, input byte_t lines,
                                input logic ack);
    byte_t      rbyte;
    logic       nack;
    pin_phase_t tail;
    int         n;
    rbyte = '0;
    nack  = 1'b0;
    case (op)
      OP_INIT: begin
        bus_sda_rel = 1'b0;
        put_phase();
      end
      OP_START: start_cond();
      OP_STOP:  stop_cond();
      OP_WRITE: begin
        shift_byte_out(data);
        // ninth clock: hold SDA low, sample nothing
        drive_sda(1'b0);
        drive_scl(1'b1);
        drive_scl(1'b0);
      end
      OP_READ_ACK, OP_READ_NACK: begin
        release_sda();
        for (int i = ByteWidth - 1; i >= 0; i--) begin
          drive_scl(1'b1);
          rbyte[i] = lines[i];
          drive_scl(1'b0);
        end
        bus_sda_rel = 1'b0;
        drive_sda(op == OP_READ_NACK);
        drive_scl(1'b1);
        drive_scl(1'b0);
      end
      OP_POLL: begin
        start_cond();
        shift_byte_out(data);
        release_sda();
        drive_scl(1'b1);
        nack = ack;
        drive_scl(1'b0);
        bus_sda_rel = 1'b0;
        stop_cond();
      end
      default: return;
    endcase
    n = pin_phases_due.size();
    tail = pin_phases_due[n-1];
    tail.ph.read_byte = rbyte;
    tail.ph.no_ack    = nack;
    tail.last         = 1'b1;
    pin_phases_due[n-1] = tail;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of commands with random gaps

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    command_t cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        cmd = cmd_pending.pop_front();
        s_axis_tuser  <= cmd.op;
        s_axis_tdata  <= {{(InDataWidth - 2*ByteWidth - 1){1'b0}}, cmd.ack, cmd.lines,
                          cmd.data};
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 6);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: stall pattern switches among always ready, random ready and stall bursts

  int sink_cycle = 0;
  int sink_mode = 0;
  int stall_left = 0;

  always @(negedge clk_i) begin
    sink_cycle++;
    if (sink_cycle % 256 == 0) begin
      sink_mode = $urandom_range(0, 2);
    end
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 8);
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Prediction on accepted commands, checking of every phase transfer

  always @(posedge clk_i or negedge rst_ni) begin
    pin_phase_t exp_p;
    phase_t     got;
    if (!rst_ni) begin
      cmd_taken   <= 1'b0;
      bus_scl     = 1'b1;
      bus_sda     = 1'b1;
      bus_sda_rel = 1'b0;
    end else begin
      cmd_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expand_command(op_e'(s_axis_tuser), s_axis_tdata[ByteWidth-1:0],
                       s_axis_tdata[2*ByteWidth-1:ByteWidth], s_axis_tdata[2*ByteWidth]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = phase_t'(m_axis_tdata);
        if (pin_phases_due.size() == 0) begin
          $display("%0t: transfer with no phase expected: tdata=%04h tlast=%0b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          exp_p = pin_phases_due.pop_front();
          if (got.scl !== exp_p.ph.scl || got.sda !== exp_p.ph.sda ||
              got.sda_released !== exp_p.ph.sda_released ||
              got.read_byte !== exp_p.ph.read_byte || got.no_ack !== exp_p.ph.no_ack ||
              got.pad !== exp_p.ph.pad || m_axis_tlast !== exp_p.last) begin
            $display("%0t: expected scl=%0b sda=%0b rel=%0b byte=%02h nack=%0b last=%0b",
                     $time, exp_p.ph.scl, exp_p.ph.sda, exp_p.ph.sda_released,
                     exp_p.ph.read_byte, exp_p.ph.no_ack, exp_p.last);
            $display("%0t: actual scl=%0b sda=%0b rel=%0b byte=%02h nack=%0b last=%0b pad=%0h",
                     $time, got.scl, got.sda, got.sda_released, got.read_byte,
                     got.no_ack, m_axis_tlast, got.pad);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus

  task automatic queue_cmd(input op_e op, input byte_t data, input byte_t lines,
                           input logic ack);
    command_t c;
    c.op    = op;
    c.data  = data;
    c.lines = lines;
    c.ack   = ack;
    cmd_pending.push_back(c);
    if (op != OP_NONE) begin
      live_cmds++;
    end
  endtask

  task automatic queue_random(input op_e op);
    queue_cmd(op, byte_t'($urandom), byte_t'($urandom), 1'($urandom));
  endtask

  initial begin
    int pick;
    int body;
    live_cmds  = 0;
    mismatches = 0;

    // directed: pin extremes, every command, ignored opcode, ack/nack on poll
    queue_cmd(OP_INIT,      8'h00, 8'h00, 1'b0);
    queue_cmd(OP_START,     8'hFF, 8'hFF, 1'b1);
    queue_cmd(OP_WRITE,     8'h00, 8'hFF, 1'b1);
    queue_cmd(OP_WRITE,     8'hFF, 8'h00, 1'b0);
    queue_cmd(OP_WRITE,     8'hA5, 8'h5A, 1'b0);
    queue_cmd(OP_READ_ACK,  8'h00, 8'hFF, 1'b0);
    queue_cmd(OP_READ_ACK,  8'hFF, 8'h00, 1'b1);
    queue_cmd(OP_READ_NACK, 8'h3C, 8'h5A, 1'b1);
    queue_cmd(OP_STOP,      8'h00, 8'h00, 1'b0);
    queue_cmd(OP_NONE,      8'hFF, 8'hFF, 1'b1);
    queue_cmd(OP_POLL,      8'hFF, 8'h00, 1'b1);
    queue_cmd(OP_POLL,      8'h00, 8'hFF, 1'b0);
    queue_cmd(OP_POLL,      8'hA0, 8'h81, 1'b1);
    queue_cmd(OP_INIT,      8'hFF, 8'hFF, 1'b1);
    queue_cmd(OP_START,     8'h00, 8'h00, 1'b0);
    queue_cmd(OP_WRITE,     8'h80, 8'h01, 1'b1);
    queue_cmd(OP_WRITE,     8'h01, 8'h80, 1'b0);
    queue_cmd(OP_READ_NACK, 8'hA5, 8'hA5, 1'b0);
    queue_cmd(OP_NONE,      8'h00, 8'h00, 1'b0);
    queue_cmd(OP_STOP,      8'hFF, 8'hFF, 1'b1);

    // random: mostly framed transactions, mixed with polls and noise
    while (live_cmds < 245) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_random(OP_START);
        body = $urandom_range(1, 4);
        for (int i = 0; i < body; i++) begin
          case ($urandom_range(0, 2))
            0:       queue_random(OP_WRITE);
            1:       queue_random(OP_READ_ACK);
            default: queue_random(OP_READ_NACK);
          endcase
        end
        queue_random(OP_STOP);
      end else if (pick < 8) begin
        queue_random(OP_POLL);
      end else begin
        queue_random(op_e'($urandom_range(0, 7)));
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pin_phases_due.size() != 0) @(posedge clk_i);
    // catch any stray phase after the last expected one
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS i2c_master_bit_sequencer");
    end else begin
      $display("FAIL i2c_master_bit_sequencer");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("%0t: timeout, %0d phases still due", $time, pin_phases_due.size());
    $display("FAIL i2c_master_bit_sequencer");
    $finish;
  end

endmodule

`default_nettype wire
